// ===== src/mahd_pkg.sv =====
`default_nettype none

package mahd_pkg;

  localparam int unsigned WINDOW  = 16;
  localparam int unsigned TOTAL_W = 16 + $clog2(WINDOW);

  localparam logic [15:0] CONV_LIMIT_RST = 16'd4000;
  localparam logic [7:0]  ERR_LIMIT_RST  = 8'd3;
  localparam logic [7:0]  MISS_MAX       = 8'd255;

  typedef enum logic {
    REG_CONV_LIMIT = 1'b0,
    REG_ERR_LIMIT  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        habituated;
    logic        new_input;
    logic        progress_valid;
    logic [15:0] progress;
    logic [15:0] mean_active;
    logic [15:0] mean_match;
  } result_t;

endpackage

`default_nettype wire

// ===== src/moving_average_habituation_detector.sv =====
// moving average habituation detector
// input channel (in_valid_i / in_ready_o) carries one word per frame: the
// active and matching cell counts. the output channel (out_valid_o /
// out_ready_i) returns one result word per input word, in order: the window
// means of both counts, the new-input flag, the streak counter as progress
// with its valid flag, and the habituated flag.
// an accepted word goes to the result register, or to the skid register while
// the receiver stalls. one word can be accepted every cycle, so a sustained
// rate of one word per cycle is reached while the receiver keeps
// up; the window update is a 16-deep shift line per count plus a running
// total, all resolved combinationally between input and result register.
// when the receiver stalls, one further word is taken into a skid register,
// after which in_ready_o drops until the result register drains.
// reset (rst_ni low, asynchronous) clears the window, totals, streak and miss
// counters and empties both output slots, and loads a streak limit of 4000
// and a miss tolerance of 3; pready is always high. the user writes the limits
// over the apb port at 0x0 and 0x4 only while the block is idle, unchecked.
`default_nettype none

module moving_average_habituation_detector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] active_count_i,
  input  wire logic [15:0] match_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             habituated_o,
  output logic             new_input_o,
  output logic             progress_valid_o,
  output logic [15:0]      progress_o,
  output logic [15:0]      mean_active_o,
  output logic [15:0]      mean_match_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mahd_pkg::*;

  logic [15:0] conv_limit_q;
  logic [7:0]  err_limit_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  logic [15:0]        hist_a_q [WINDOW];
  logic [15:0]        hist_m_q [WINDOW];
  logic [TOTAL_W-1:0] tot_a_q, tot_a_d;
  logic [TOTAL_W-1:0] tot_m_q, tot_m_d;
  logic [15:0]        streak_q, streak_d;
  logic [7:0]         miss_q, miss_d;

  logic        acc;
  logic        out_fire;
  logic        is_match;
  logic        is_quiet;
  result_t     res_new;
  result_t     res_q, res_d;
  result_t     skid_q, skid_d;
  logic        out_vld_q, out_vld_d;
  logic        skid_vld_q, skid_vld_d;

  // apb register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_CONV_LIMIT: prdata = {16'd0, conv_limit_q};
      REG_ERR_LIMIT:  prdata = {24'd0, err_limit_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_limit_q <= CONV_LIMIT_RST;
      err_limit_q  <= ERR_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CONV_LIMIT: conv_limit_q <= pwdata[15:0];
        REG_ERR_LIMIT:  err_limit_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_ready_o = !skid_vld_q;
  assign acc        = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  // window totals and detection
  always_comb begin
    tot_a_d = tot_a_q - TOTAL_W'(hist_a_q[0]) + TOTAL_W'(active_count_i);
    tot_m_d = tot_m_q - TOTAL_W'(hist_m_q[0]) + TOTAL_W'(match_count_i);

    res_new             = '0;
    res_new.mean_active = 16'(tot_a_d / WINDOW);
    res_new.mean_match  = 16'(tot_m_d / WINDOW);
    res_new.new_input   = (match_count_i < res_new.mean_match) ||
                          (active_count_i < res_new.mean_active);

    is_match = (active_count_i != 16'd0) && (active_count_i == match_count_i);
    is_quiet = (active_count_i == 16'd0) && (match_count_i == 16'd0) &&
               (res_new.mean_active != 16'd0) &&
               (res_new.mean_active == res_new.mean_match);

    streak_d = streak_q;
    miss_d   = miss_q;
    if (is_match) begin
      res_new.progress_valid = 1'b1;
      res_new.progress       = streak_q;
      miss_d                 = 8'd0;
      if (streak_q >= conv_limit_q) begin
        res_new.habituated = 1'b1;
      end else begin
        streak_d = streak_q + 16'd1;
      end
    end else if (is_quiet) begin
      if (miss_q != MISS_MAX) begin
        miss_d = miss_q + 8'd1;
      end
      res_new.progress_valid = 1'b1;
      res_new.progress       = streak_q;
    end else if (miss_q < err_limit_q) begin
      miss_d = miss_q + 8'd1;
    end else begin
      res_new.progress_valid = 1'b1;
      miss_d                 = 8'd0;
      streak_d               = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_a_q[i] <= 16'd0;
        hist_m_q[i] <= 16'd0;
      end
      tot_a_q  <= '0;
      tot_m_q  <= '0;
      streak_q <= 16'd0;
      miss_q   <= 8'd0;
    end else if (acc) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        hist_a_q[i] <= hist_a_q[i+1];
        hist_m_q[i] <= hist_m_q[i+1];
      end
      hist_a_q[WINDOW-1] <= active_count_i;
      hist_m_q[WINDOW-1] <= match_count_i;
      tot_a_q  <= tot_a_d;
      tot_m_q  <= tot_m_d;
      streak_q <= streak_d;
      miss_q   <= miss_d;
    end
  end

  // result register with skid slot
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    res_d      = res_q;
    skid_d     = skid_q;
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        res_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (acc) begin
        res_d     = res_new;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (acc) begin
      skid_d     = res_new;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_vld_q;
  assign habituated_o     = res_q.habituated;
  assign new_input_o      = res_q.new_input;
  assign progress_valid_o = res_q.progress_valid;
  assign progress_o       = res_q.progress;
  assign mean_active_o    = res_q.mean_active;
  assign mean_match_o     = res_q.mean_match;

endmodule

`default_nettype wire

// ===== src/mahd_checker.sv =====
`default_nettype none

module mahd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        habituated_o,
  input wire logic        progress_valid_o,
  input wire logic [15:0] progress_o,
  input wire logic [15:0] mean_active_o,
  input wire logic [15:0] mean_match_o
);

  // after an accepted word, out_valid_o is always high in the next cycle
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // back-pressure on the input only while a result waits
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // habituation is only reported with a valid progress value; else progress is zero
  a_habit_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (habituated_o || !progress_valid_o) |->
      progress_valid_o || (progress_o == 16'd0 && !habituated_o))
    else $error("habituated or progress without progress_valid");

  // a stalled result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(progress_o) && $stable(mean_active_o) &&
      $stable(mean_match_o))
    else $error("stalled output word changed");

endmodule

bind moving_average_habituation_detector mahd_checker u_mahd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .habituated_o     (habituated_o),
  .progress_valid_o (progress_valid_o),
  .progress_o       (progress_o),
  .mean_active_o    (mean_active_o),
  .mean_match_o     (mean_match_o)
);

`default_nettype wire
